### rtl/fsq_pkg.sv
package fsq_pkg;

   localparam int LETTER_W   = 5;
   localparam int SQ_DIM     = 5;
   localparam int IDX_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int ROW_W      = SQ_DIM * LETTER_W;
   localparam int CSR_DATA_W = 2 * ROW_W;
   localparam int TDATA_W    = 16;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef letter_type [SQ_DIM-1:0] row_type;
   typedef row_type [SQ_DIM-1:0] square_type;

   localparam letter_type LETTER_I = letter_type'(8);
   localparam letter_type LETTER_J = letter_type'(9);

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_ONE_ROWS_01 = 3'd0,
      CSR_KEY_ONE_ROWS_23 = 3'd1,
      CSR_KEY_ONE_ROW_4   = 3'd2,
      CSR_KEY_TWO_ROWS_01 = 3'd3,
      CSR_KEY_TWO_ROWS_23 = 3'd4,
      CSR_KEY_TWO_ROW_4   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic    found;
      idx_type row;
      idx_type col;
   } pos_type;

   typedef struct packed {
      letter_type first_out;
      letter_type second_out;
      logic       not_found;
   } result_type;

   // alphabet without j, row-major
   function automatic square_type build_plain_square();
      square_type sq;
      sq = '0;
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++) begin
            if (r * SQ_DIM + c < 9) begin
               sq[r][c] = letter_type'(r * SQ_DIM + c);
            end else begin
               sq[r][c] = letter_type'(r * SQ_DIM + c + 1);
            end
         end
      end
      return sq;
   endfunction

   localparam square_type PLAIN_SQUARE = build_plain_square();

   // last match in row-major order wins
   function automatic pos_type find_letter(square_type sq, letter_type letter);
      pos_type pos;
      pos = '0;
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++) begin
            if (sq[r][c] == letter) begin
               pos.found = 1'b1;
               pos.row   = idx_type'(r);
               pos.col   = idx_type'(c);
            end
         end
      end
      return pos;
   endfunction

endpackage

### rtl/fsq_lookup.sv
module fsq_lookup (
   input  logic                   cmd,
   input  fsq_pkg::letter_type    first_letter,
   input  fsq_pkg::letter_type    second_letter,
   input  fsq_pkg::square_type    key_one,
   input  fsq_pkg::square_type    key_two,
   output fsq_pkg::result_type    result
);
   import fsq_pkg::*;

   square_type find_one;
   square_type find_two;
   pos_type    pos_a;
   pos_type    pos_b;

   // encrypt looks up in the plain square, decrypt in the keyed squares
   always_comb begin
      if (cmd == CMD_DECRYPT) begin
         find_one = key_one;
         find_two = key_two;
      end else begin
         find_one = PLAIN_SQUARE;
         find_two = PLAIN_SQUARE;
      end
   end

   assign pos_a = find_letter(find_one, first_letter);
   assign pos_b = find_letter(find_two, second_letter);

   always_comb begin
      result = '0;
      if (!pos_a.found || !pos_b.found) begin
         result.not_found = 1'b1;
      end else if (cmd == CMD_DECRYPT) begin
         result.first_out  = PLAIN_SQUARE[pos_a.row][pos_b.col];
         result.second_out = PLAIN_SQUARE[pos_b.row][pos_a.col];
      end else begin
         result.first_out  = key_one[pos_a.row][pos_b.col];
         result.second_out = key_two[pos_b.row][pos_a.col];
      end
   end

endmodule

### rtl/four_square_digram_cipher.sv
// four-square digram cipher, one digram per beat
//
// req channel: tdata carries the two input letters (codes 0..25 for a..z),
// tuser carries the command (0 encrypt, 1 decrypt). rsp channel: tdata carries
// the two result letters, tuser the not_found flag (set, with both letters
// zero, when an input letter is absent from the square it is looked up in).
// csr channel writes the two keyed squares; csr_ready is always high, writes
// are expected only while no digram is in flight.
//
// a beat accepted on req is captured in the input register, the combinational
// lookup runs between that register and the result register, and the result
// is presented on rsp from the result register. throughput: one digram per
// cycle while the receiver does not stall, with the combinational lookup
// between the two register stages.
// reset clears both key squares to zero and empties both stages. when the
// receiver stalls, the result register holds its beat and the input register
// still takes one more digram before req_tready drops.
module four_square_digram_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [4:0] first_letter, [9:5] second_letter, rest zero
   input  logic [fsq_pkg::TDATA_W-1:0]        req_tdata,
   // [0] cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] first_out, [9:5] second_out, rest zero
   output logic [fsq_pkg::TDATA_W-1:0]        rsp_tdata,
   // [0] not_found
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fsq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsq_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fsq_pkg::*;

   // key squares
   square_type key_one_ff, key_one_in;
   square_type key_two_ff, key_two_in;

   // input stage
   logic       req_v_ff, req_v_in;
   logic       cmd_ff, cmd_in;
   letter_type first_ff, first_in;
   letter_type second_ff, second_in;

   // result stage
   logic       rsp_v_ff, rsp_v_in;
   result_type rsp_data_ff, rsp_data_in;

   result_type lookup_result;
   logic       rsp_free;
   logic       req_fire;
   logic       advance;

   assign csr_ready = 1'b1;

   // config writes, one or two rows per beat; out-of-range index is ignored
   always_comb begin
      key_one_in = key_one_ff;
      key_two_in = key_two_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_ONE_ROWS_01: begin
               key_one_in[0] = row_type'(csr_data[ROW_W-1:0]);
               key_one_in[1] = row_type'(csr_data[CSR_DATA_W-1:ROW_W]);
            end
            CSR_KEY_ONE_ROWS_23: begin
               key_one_in[2] = row_type'(csr_data[ROW_W-1:0]);
               key_one_in[3] = row_type'(csr_data[CSR_DATA_W-1:ROW_W]);
            end
            CSR_KEY_ONE_ROW_4: begin
               key_one_in[4] = row_type'(csr_data[ROW_W-1:0]);
            end
            CSR_KEY_TWO_ROWS_01: begin
               key_two_in[0] = row_type'(csr_data[ROW_W-1:0]);
               key_two_in[1] = row_type'(csr_data[CSR_DATA_W-1:ROW_W]);
            end
            CSR_KEY_TWO_ROWS_23: begin
               key_two_in[2] = row_type'(csr_data[ROW_W-1:0]);
               key_two_in[3] = row_type'(csr_data[CSR_DATA_W-1:ROW_W]);
            end
            CSR_KEY_TWO_ROW_4: begin
               key_two_in[4] = row_type'(csr_data[ROW_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline flow: result register frees up when empty or taken this cycle
   assign rsp_free   = !rsp_v_ff || rsp_tready;
   assign advance    = req_v_ff && rsp_free;
   assign req_tready = !req_v_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      req_v_in  = req_v_ff;
      cmd_in    = cmd_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (req_fire) begin
         req_v_in  = 1'b1;
         cmd_in    = req_tuser;
         first_in  = req_tdata[LETTER_W-1:0];
         second_in = req_tdata[2*LETTER_W-1:LETTER_W];
      end else if (advance) begin
         req_v_in = 1'b0;
      end
   end

   fsq_lookup u_lookup (
      .cmd           (cmd_ff),
      .first_letter  (first_ff),
      .second_letter (second_ff),
      .key_one       (key_one_ff),
      .key_two       (key_two_ff),
      .result        (lookup_result)
   );

   always_comb begin
      rsp_v_in    = rsp_v_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_v_in    = 1'b1;
         rsp_data_in = lookup_result;
      end else if (rsp_tready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff <= '0;
         key_two_ff <= '0;
         req_v_ff   <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         key_one_ff <= key_one_in;
         key_two_ff <= key_two_in;
         req_v_ff   <= req_v_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{(TDATA_W - 2*LETTER_W){1'b0}},
                        rsp_data_ff.second_out, rsp_data_ff.first_out};
   assign rsp_tuser  = rsp_data_ff.not_found;

   // both stages come up empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !req_v_ff && !rsp_v_ff)
      else $error("pipeline not empty after reset");

   // a digram leaving the input stage always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_v_ff)
      else $error("digram lost between stages");

   // a missing letter gives zero result letters
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_data_ff.not_found |->
         rsp_data_ff.first_out == '0 && rsp_data_ff.second_out == '0)
      else $error("not_found beat carries letters");

   // j never sits in the plain square, so encrypting it must flag
   a_encrypt_j: assert property (@(posedge clock) disable iff (reset)
      advance && cmd_ff == CMD_ENCRYPT && first_ff == LETTER_J |=>
         rsp_data_ff.not_found)
      else $error("encrypt of j not flagged");

   // a stalled result beat stays put until taken
   a_no_stall_loss: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready && !advance |=> rsp_v_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");

endmodule

### dv/four_square_digram_cipher_test.sv
module four_square_digram_cipher_test;
   import fsq_pkg::*;

   // no acceptance on any channel for this many cycles ends the run
   localparam int WATCHDOG_LIMIT = 3000;
   // two register stages, plus margin, before a key write or the end
   localparam int SETTLE_CYCLES  = 6;
   localparam int CELLS          = SQ_DIM * SQ_DIM;
   localparam int MISMATCH_LINES = 100;
   localparam letter_type LETTER_Z        = letter_type'(25);
   localparam letter_type LETTER_CODE_MAX = letter_type'(31);

   // one keyed square, entry row*5+col
   typedef letter_type [CELLS-1:0] key_table_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PATTERN,
      READY_SPARSE
   } ready_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [4:0] first_letter, [9:5] second_letter, rest zero
   logic [TDATA_W-1:0]     req_tdata  = '0;
   // [0] cmd
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [4:0] first_out, [9:5] second_out, rest zero
   logic [TDATA_W-1:0]     rsp_tdata;
   // [0] not_found
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // shadow copy of the two keyed squares
   key_table_type key_one = '0;
   key_table_type key_two = '0;

   // expected results, oldest first
   result_type pending_digrams[$];

   int mismatch_count = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             ready_phase = 0;

   four_square_digram_cipher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // cipher prediction
   // ---------------------------------------------------------------------

   // entry of a letter in the plain square (alphabet without j), -1 if absent
   function automatic int plain_cell(letter_type c);
      if (c < LETTER_J) return int'(c);
      if (c == LETTER_J || c > LETTER_Z) return -1;
      return int'(c) - 1;
   endfunction

   function automatic letter_type plain_letter_at(int entry);
      return (entry < int'(LETTER_J)) ? letter_type'(entry) : letter_type'(entry + 1);
   endfunction

   // later entries overwrite earlier ones, so a repeated letter resolves to its last entry
   function automatic int key_cell(key_table_type sq, letter_type c);
      int entry;
      entry = -1;
      for (int e = 0; e < CELLS; e++) begin
         if (sq[e] == c) entry = e;
      end
      return entry;
   endfunction

   function automatic result_type cipher_digram(cmd_type cmd, letter_type a, letter_type b);
      result_type r;
      int         pa;
      int         pb;
      r = '0;
      if (cmd == CMD_ENCRYPT) begin
         pa = plain_cell(a);
         pb = plain_cell(b);
      end else begin
         pa = key_cell(key_one, a);
         pb = key_cell(key_two, b);
      end
      // letter missing from its lookup square: flag only, letters stay zero
      if (pa < 0 || pb < 0) begin
         r.not_found = 1'b1;
         return r;
      end
      // swap columns between the two looked-up entries
      if (cmd == CMD_ENCRYPT) begin
         r.first_out  = key_one[(pa / SQ_DIM) * SQ_DIM + pb % SQ_DIM];
         r.second_out = key_two[(pb / SQ_DIM) * SQ_DIM + pa % SQ_DIM];
      end else begin
         r.first_out  = plain_letter_at((pa / SQ_DIM) * SQ_DIM + pb % SQ_DIM);
         r.second_out = plain_letter_at((pb / SQ_DIM) * SQ_DIM + pa % SQ_DIM);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // key square builders
   // ---------------------------------------------------------------------

   // classic keyed square: the 25 plain letters in random order
   function automatic key_table_type shuffled_alphabet();
      key_table_type sq;
      letter_type    swap;
      int            j;
      for (int e = 0; e < CELLS; e++) sq[e] = plain_letter_at(e);
      for (int e = CELLS - 1; e > 0; e--) begin
         j      = $urandom_range(0, e);
         swap   = sq[e];
         sq[e]  = sq[j];
         sq[j]  = swap;
      end
      return sq;
   endfunction

   // any 5-bit code: repeats, j and codes above z all show up
   function automatic key_table_type random_codes();
      key_table_type sq;
      for (int e = 0; e < CELLS; e++) sq[e] = letter_type'($urandom_range(0, 31));
      return sq;
   endfunction

   function automatic key_table_type uniform_key(letter_type c);
      key_table_type sq;
      for (int e = 0; e < CELLS; e++) sq[e] = c;
      return sq;
   endfunction

   // register image of count entries starting at first, lowest entry in the lowest bits
   function automatic logic [CSR_DATA_W-1:0] pack_cells(key_table_type sq, int first,
                                                         int count);
      logic [CSR_DATA_W-1:0] v;
      v = '0;
      for (int i = 0; i < count; i++) v[i*LETTER_W +: LETTER_W] = sq[first + i];
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // one digram beat; bursts of random length separated by random gaps
   task automatic send_digram(cmd_type cmd, letter_type a, letter_type b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'({b, a});
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_digrams.push_back(cipher_digram(cmd, a, b));
   endtask

   // stop sending and let every result in flight come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_digrams.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays up across back-to-back writes
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_squares(key_table_type one, key_table_type two);
      wait_idle();
      write_register(CSR_KEY_ONE_ROWS_01, pack_cells(one, 0, 10));
      write_register(CSR_KEY_ONE_ROWS_23, pack_cells(one, 10, 10));
      write_register(CSR_KEY_ONE_ROW_4,   pack_cells(one, 20, 5));
      write_register(CSR_KEY_TWO_ROWS_01, pack_cells(two, 0, 10));
      write_register(CSR_KEY_TWO_ROWS_23, pack_cells(two, 10, 10));
      write_register(CSR_KEY_TWO_ROW_4,   pack_cells(two, 20, 5));
      csr_valid <= 1'b0;
      key_one = one;
      key_two = two;
   endtask

   // mostly digrams that hit their squares, the rest raw 5-bit noise
   task automatic send_random_digrams(int count);
      cmd_type    cmd;
      letter_type a;
      letter_type b;
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            cmd = cmd_type'($urandom_range(0, 1));
            a   = letter_type'($urandom_range(0, 31));
            b   = letter_type'($urandom_range(0, 31));
         end else if ($urandom_range(0, 1) == 0) begin
            cmd = CMD_ENCRYPT;
            a   = plain_letter_at($urandom_range(0, CELLS - 1));
            b   = plain_letter_at($urandom_range(0, CELLS - 1));
         end else begin
            cmd = CMD_DECRYPT;
            a   = key_one[$urandom_range(0, CELLS - 1)];
            b   = key_two[$urandom_range(0, CELLS - 1)];
         end
         send_digram(cmd, a, b);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // squares are all zero out of reset: every key entry repeats letter a
   task automatic test_reset_squares();
      send_digram(CMD_ENCRYPT, letter_type'(0), letter_type'(0));
      send_digram(CMD_ENCRYPT, LETTER_Z, letter_type'(24));
      // a found in all 25 entries, the last one wins
      send_digram(CMD_DECRYPT, letter_type'(0), letter_type'(0));
      send_digram(CMD_DECRYPT, letter_type'(1), letter_type'(0));
      send_digram(CMD_ENCRYPT, LETTER_J, letter_type'(0));
   endtask

   // hand-built squares with a repeat and codes beyond z
   task automatic test_directed_digrams();
      key_table_type one;
      key_table_type two;
      for (int e = 0; e < CELLS; e++) begin
         one[e] = plain_letter_at(CELLS - 1 - e);
         two[e] = plain_letter_at((e * 7) % CELLS);
      end
      one[3]  = LETTER_CODE_MAX;
      one[20] = one[5];
      two[24] = letter_type'(26);
      program_squares(one, two);

      send_digram(CMD_ENCRYPT, letter_type'(0), LETTER_Z);
      send_digram(CMD_ENCRYPT, LETTER_Z, letter_type'(0));
      send_digram(CMD_ENCRYPT, LETTER_I, letter_type'(10));
      // j and codes above z are not in the plain square
      send_digram(CMD_ENCRYPT, LETTER_J, letter_type'(1));
      send_digram(CMD_ENCRYPT, letter_type'(2), LETTER_J);
      send_digram(CMD_ENCRYPT, LETTER_CODE_MAX, LETTER_CODE_MAX);
      send_digram(CMD_ENCRYPT, letter_type'(26), LETTER_Z);
      // out-of-range key codes match as plain codes
      send_digram(CMD_DECRYPT, LETTER_CODE_MAX, letter_type'(26));
      // repeated key letter resolves to its later entry
      send_digram(CMD_DECRYPT, one[5], two[0]);
      send_digram(CMD_DECRYPT, LETTER_J, LETTER_J);
      send_digram(CMD_DECRYPT, one[0], LETTER_CODE_MAX);
      send_digram(CMD_DECRYPT, one[24], two[12]);
   endtask

   // every key entry at the top code
   task automatic test_uniform_squares();
      program_squares(uniform_key(LETTER_CODE_MAX), uniform_key(LETTER_CODE_MAX));
      send_digram(CMD_ENCRYPT, letter_type'(0), LETTER_Z);
      send_digram(CMD_DECRYPT, LETTER_CODE_MAX, LETTER_CODE_MAX);
      send_digram(CMD_DECRYPT, letter_type'(0), letter_type'(0));
   endtask

   // sender stops mid-stream until the pipeline has fully drained
   task automatic test_pause_until_drained();
      program_squares(shuffled_alphabet(), shuffled_alphabet());
      send_random_digrams(60);
      req_tvalid <= 1'b0;
      while (pending_digrams.size() != 0) @(posedge clock);
      send_random_digrams(60);
   endtask

   task automatic test_random_traffic();
      program_squares(shuffled_alphabet(), shuffled_alphabet());
      send_random_digrams(150);
      program_squares(random_codes(), random_codes());
      send_random_digrams(150);
      program_squares(uniform_key(letter_type'(0)), random_codes());
      send_random_digrams(30);
      program_squares(shuffled_alphabet(), random_codes());
      send_random_digrams(150);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_squares();
      test_directed_digrams();
      test_uniform_squares();
      test_pause_until_drained();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // receiver, checker, watchdog
   // ---------------------------------------------------------------------

   // receiver switches among always ready, coin flip, fixed pattern and sparse
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 160);
      end
      mode_left--;
      ready_phase++;
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_COIN: begin
            rsp_tready <= ($urandom_range(0, 1) == 1);
         end
         READY_PATTERN: begin
            rsp_tready <= ((ready_phase % 5) < 3);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 4) == 0);
         end
      endcase
   end

   task automatic report_mismatch(string field, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_LINES) begin
         $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digrams.size() == 0) begin
            report_mismatch("unexpected beat", int'(rsp_tdata), 0);
         end else begin
            want = pending_digrams.pop_front();
            if (rsp_tdata[LETTER_W-1:0] != want.first_out) begin
               report_mismatch("first_out", int'(rsp_tdata[LETTER_W-1:0]),
                               int'(want.first_out));
            end
            if (rsp_tdata[2*LETTER_W-1:LETTER_W] != want.second_out) begin
               report_mismatch("second_out", int'(rsp_tdata[2*LETTER_W-1:LETTER_W]),
                               int'(want.second_out));
            end
            if (rsp_tuser != want.not_found) begin
               report_mismatch("not_found", int'(rsp_tuser), int'(want.not_found));
            end
         end
      end
   end

   // any beat on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
